/* design/ggvc_pkg.sv */
`timescale 1ns / 1ps

package ggvc_pkg;

    // CORDIC datapath: prescaled vectors, Q.16 angle accumulator
    localparam int VW = 46;
    localparam int ZW = 20;
    // signed Q4.13 angles after rounding and the heading error
    localparam int AW = 18;
    // magnitude as used for the distance product
    localparam int MW = 43;
    localparam int PW = MW + 16;
    // distance in Q16.16 with headroom above 32 bits
    localparam int DW = PW - 24;
    localparam int GW = 20;

    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [AW-1:0] PI_Q13      = 18'sd25736;
    localparam logic signed [AW-1:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic [15:0]          INV_K_Q16   = 16'd39797;

    localparam logic [2:0] REG_GOAL_POS_X       = 3'd0;
    localparam logic [2:0] REG_GOAL_POS_Y       = 3'd1;
    localparam logic [2:0] REG_ARRIVE_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_LINEAR_GAIN      = 3'd3;
    localparam logic [2:0] REG_MAX_LINEAR_SPEED = 3'd4;
    localparam logic [2:0] REG_ANGULAR_GAIN     = 3'd5;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } pose_t;

    typedef struct packed {
        logic [31:0]        linear_speed;
        logic signed [31:0] angular_rate;
        logic               goal_reached;
    } cmd_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cvec_t;

    typedef struct packed {
        cvec_t pos;
        cvec_t head;
    } cord_t;

    typedef struct packed {
        logic [31:0]   arrive_tolerance;
        logic [GW-1:0] linear_gain;
        logic [31:0]   max_linear_speed;
        logic [GW-1:0] angular_gain;
    } cfg_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:    a = 20'sd51472;
            5'd1:    a = 20'sd30386;
            5'd2:    a = 20'sd16055;
            5'd3:    a = 20'sd8150;
            5'd4:    a = 20'sd4091;
            5'd5:    a = 20'sd2047;
            5'd6:    a = 20'sd1024;
            5'd7:    a = 20'sd512;
            5'd8:    a = 20'sd256;
            5'd9:    a = 20'sd128;
            5'd10:   a = 20'sd64;
            5'd11:   a = 20'sd32;
            5'd12:   a = 20'sd16;
            5'd13:   a = 20'sd8;
            5'd14:   a = 20'sd4;
            5'd15:   a = 20'sd2;
            5'd16:   a = 20'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Prescale by 256 and fold the left half-plane onto the right one
    function automatic cvec_t cordic_init(input logic signed [VW-1:0] x,
                                          input logic signed [VW-1:0] y);
        cvec_t                v;
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        xs     = x <<< 8;
        ys     = y <<< 8;
        v.zero = (x == '0) && (y == '0);
        v.x    = xs;
        v.y    = ys;
        v.z    = '0;
        if (xs[VW-1]) begin
            if (!ys[VW-1]) begin
                v.x = ys;
                v.y = -xs;
                v.z = HALF_PI_Q16;
            end else begin
                v.x = -ys;
                v.y = xs;
                v.z = -HALF_PI_Q16;
            end
        end
        return v;
    endfunction

endpackage

/* design/go_to_goal_velocity_controller.sv */
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// pose in   s_valid / s_ready   s_data  (ggvc_pkg::pose_t)
// cmd out   m_valid / m_ready   m_data  (ggvc_pkg::cmd_t)
// config    cfg_wen             cfg_index, cfg_wdata
//
// A new pose can enter every cycle while m_ready does not stall the output; each gives one command.
// Both vectors pass through one shared CORDIC pipeline, one stage per micro-rotation,
// plus two front stages (differences and quaternion products; yaw vector and fold) and four back stages.
// Reset clears the stage valid bits and loads the register defaults.
// A stall on m_ready only halts stages that are full, so bubbles close up.

module go_to_goal_velocity_controller #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ggvc_pkg::pose_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ggvc_pkg::cmd_t   m_data,
    input  logic             cfg_wen,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_wdata
);

    logic signed [31:0] goal_x_reg, goal_y_reg;
    ggvc_pkg::cfg_t     cfg_reg;
    logic               f_valid, f_ready, c_valid, c_ready;
    ggvc_pkg::cord_t    f_data, c_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg               <= '0;
            goal_y_reg               <= '0;
            cfg_reg.arrive_tolerance <= 32'd6554;
            cfg_reg.linear_gain      <= 20'd32768;
            cfg_reg.max_linear_speed <= 32'd19661;
            cfg_reg.angular_gain     <= 20'd52429;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                ggvc_pkg::REG_GOAL_POS_X:       goal_x_reg <= cfg_wdata;
                ggvc_pkg::REG_GOAL_POS_Y:       goal_y_reg <= cfg_wdata;
                ggvc_pkg::REG_ARRIVE_TOLERANCE: cfg_reg.arrive_tolerance <= cfg_wdata;
                ggvc_pkg::REG_LINEAR_GAIN:      cfg_reg.linear_gain <= cfg_wdata[19:0];
                ggvc_pkg::REG_MAX_LINEAR_SPEED: cfg_reg.max_linear_speed <= cfg_wdata;
                ggvc_pkg::REG_ANGULAR_GAIN:     cfg_reg.angular_gain <= cfg_wdata[19:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    ggvc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .goal_x   (goal_x_reg),
        .goal_y   (goal_y_reg),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_data (f_data)
    );

    ggvc_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (f_data),
        .out_valid(c_valid),
        .out_ready(c_ready),
        .out_data (c_data)
    );

    ggvc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (c_valid),
        .in_ready (c_ready),
        .in_data  (c_data),
        .cfg      (cfg_reg),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (m_data)
    );

endmodule

/* design/ggvc_front.sv */
`timescale 1ns / 1ps

module ggvc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ggvc_pkg::pose_t    in_data,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    output logic               out_valid,
    input  logic               out_ready,
    output ggvc_pkg::cord_t    out_data
);

    logic               a_v_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [31:0] yy_reg, zz_reg, wz_reg, xy_reg;
    logic signed [32:0] dx_next, dy_next;
    logic signed [31:0] yy_next, zz_next, wz_next, xy_next;
    logic               b_v_reg;
    ggvc_pkg::cord_t    b_reg, b_next;
    logic signed [32:0] sq_sum, cross_sum;
    logic signed [ggvc_pkg::VW-1:0] xq, yq;
    logic               en_a, en_b;

    assign en_b     = !b_v_reg || out_ready;
    assign en_a     = !a_v_reg || en_b;
    assign in_ready = en_a;

    assign dx_next = $signed({goal_x[31], goal_x}) - $signed({in_data.pose_x[31], in_data.pose_x});
    assign dy_next = $signed({goal_y[31], goal_y}) - $signed({in_data.pose_y[31], in_data.pose_y});
    assign yy_next = in_data.quat_y * in_data.quat_y;
    assign zz_next = in_data.quat_z * in_data.quat_z;
    assign wz_next = in_data.quat_w * in_data.quat_z;
    assign xy_next = in_data.quat_x * in_data.quat_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en_a) begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            wz_reg <= wz_next;
            xy_reg <= xy_next;
        end
    end

    // yaw vector: (1 - 2(y^2 + z^2), 2(wz + xy)) in Q.28
    always_comb begin
        sq_sum     = $signed({yy_reg[31], yy_reg}) + $signed({zz_reg[31], zz_reg});
        cross_sum  = $signed({wz_reg[31], wz_reg}) + $signed({xy_reg[31], xy_reg});
        xq         = (ggvc_pkg::VW'(1) <<< 28) - (ggvc_pkg::VW'(sq_sum) <<< 1);
        yq         = ggvc_pkg::VW'(cross_sum) <<< 1;
        b_next.pos  = ggvc_pkg::cordic_init(ggvc_pkg::VW'(dx_reg), ggvc_pkg::VW'(dy_reg));
        b_next.head = ggvc_pkg::cordic_init(xq, yq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en_b) begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_v_reg;
    assign out_data  = b_reg;

endmodule

/* design/ggvc_cordic_stage.sv */
`timescale 1ns / 1ps

module ggvc_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ggvc_pkg::cord_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ggvc_pkg::cord_t out_data
);

    localparam logic signed [ggvc_pkg::ZW-1:0] ATAN = ggvc_pkg::atan_q16(5'(SHIFT));

    logic            v_reg;
    ggvc_pkg::cord_t d_reg, d_next;
    logic            en;

    // one micro-rotation towards the x axis
    function automatic ggvc_pkg::cvec_t rot(input ggvc_pkg::cvec_t v);
        ggvc_pkg::cvec_t                r;
        logic signed [ggvc_pkg::VW-1:0] x, y, sx, sy;
        logic signed [ggvc_pkg::ZW-1:0] z;
        x  = v.x;
        y  = v.y;
        z  = v.z;
        sx = x >>> SHIFT;
        sy = y >>> SHIFT;
        r  = v;
        if (!y[ggvc_pkg::VW-1]) begin
            r.x = x + sy;
            r.y = y - sx;
            r.z = z + ATAN;
        end else begin
            r.x = x - sy;
            r.y = y + sx;
            r.z = z - ATAN;
        end
        return r;
    endfunction

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        d_next.pos  = rot(in_data.pos);
        d_next.head = rot(in_data.head);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

/* design/ggvc_cordic.sv */
`timescale 1ns / 1ps

module ggvc_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ggvc_pkg::cord_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ggvc_pkg::cord_t out_data
);

    logic            valid_w [CORDIC_STAGES+1];
    logic            ready_w [CORDIC_STAGES+1];
    ggvc_pkg::cord_t data_w  [CORDIC_STAGES+1];

    assign valid_w[0]             = in_valid;
    assign data_w[0]              = in_data;
    assign in_ready               = ready_w[0];
    assign out_valid              = valid_w[CORDIC_STAGES];
    assign out_data               = data_w[CORDIC_STAGES];
    assign ready_w[CORDIC_STAGES] = out_ready;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        ggvc_cordic_stage #(
            .SHIFT(i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_w[i]),
            .in_ready (ready_w[i]),
            .in_data  (data_w[i]),
            .out_valid(valid_w[i+1]),
            .out_ready(ready_w[i+1]),
            .out_data (data_w[i+1])
        );
    end

endmodule

/* design/ggvc_back.sv */
`timescale 1ns / 1ps

module ggvc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ggvc_pkg::cord_t in_data,
    input  ggvc_pkg::cfg_t  cfg,
    output logic            out_valid,
    input  logic            out_ready,
    output ggvc_pkg::cmd_t  out_data
);

    localparam int AW = ggvc_pkg::AW;
    localparam int PW = ggvc_pkg::PW;
    localparam int DW = ggvc_pkg::DW;
    localparam int MW = ggvc_pkg::MW;
    localparam int GW = ggvc_pkg::GW;
    localparam int SW = GW + DW;
    localparam int RW = GW + 1 + AW;

    logic                 c_v_reg, d_v_reg, e_v_reg, f_v_reg;
    logic                 en_c, en_d, en_e, en_f;
    logic signed [AW-1:0] c_err_reg, c_err_next;
    logic [PW-1:0]        c_prod_reg, c_prod_next;
    logic signed [AW-1:0] bearing, yaw, diff;
    logic [MW-1:0]        mag;
    logic signed [AW-1:0] d_err_reg;
    logic [DW-1:0]        d_dist_reg, d_dist_next;
    logic                 d_reached_reg;
    logic [PW-1:0]        prod_rnd;
    logic [SW-1:0]        e_sp_reg;
    logic signed [RW-1:0] e_rp_reg;
    logic                 e_reached_reg;
    logic [SW-1:0]        sp_rnd;
    logic [SW-17:0]       speed;
    logic signed [RW-1:0] rp_rnd;
    logic signed [RW-14:0] rate;
    ggvc_pkg::cmd_t       f_reg, f_next;

    function automatic logic signed [AW-1:0] round_ang(input ggvc_pkg::cvec_t v);
        logic signed [ggvc_pkg::ZW-1:0] zr;
        zr = v.z + ggvc_pkg::ZW'(4);
        return v.zero ? '0 : AW'(zr >>> 3);
    endfunction

    assign en_f     = !f_v_reg || out_ready;
    assign en_e     = !e_v_reg || en_f;
    assign en_d     = !d_v_reg || en_e;
    assign en_c     = !c_v_reg || en_d;
    assign in_ready = en_c;

    // round angles, wrap the heading error, scale the magnitude to remove the CORDIC gain
    always_comb begin
        bearing = round_ang(in_data.pos);
        yaw     = round_ang(in_data.head);
        diff    = bearing - yaw;
        if (diff > ggvc_pkg::PI_Q13) begin
            c_err_next = diff - ggvc_pkg::TWO_PI_Q13;
        end else if (diff < -ggvc_pkg::PI_Q13) begin
            c_err_next = diff + ggvc_pkg::TWO_PI_Q13;
        end else begin
            c_err_next = diff;
        end
        mag         = in_data.pos.zero ? '0 : in_data.pos.x[MW-1:0];
        c_prod_next = PW'(mag) * PW'(ggvc_pkg::INV_K_Q16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end else begin
            if (en_c) begin
                c_v_reg <= in_valid;
            end
            if (en_d) begin
                d_v_reg <= c_v_reg;
            end
            if (en_e) begin
                e_v_reg <= d_v_reg;
            end
            if (en_f) begin
                f_v_reg <= e_v_reg;
            end
        end
    end

    assign prod_rnd    = c_prod_reg + (PW'(1) << 23);
    assign d_dist_next = prod_rnd[PW-1:24];

    assign sp_rnd = e_sp_reg + (SW'(1) << 15);
    assign speed  = sp_rnd[SW-1:16];
    assign rp_rnd = e_rp_reg + (RW'(1) <<< 12);
    // the rounded rate is far inside the 32 bit range, so extension is exact
    assign rate   = rp_rnd[RW-1:13];

    always_comb begin
        f_next.goal_reached = e_reached_reg;
        f_next.linear_speed = (speed > (SW-16)'(cfg.max_linear_speed))
                            ? cfg.max_linear_speed : speed[31:0];
        f_next.angular_rate = 32'(rate);
        if (e_reached_reg) begin
            f_next.linear_speed = '0;
            f_next.angular_rate = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_err_reg  <= c_err_next;
            c_prod_reg <= c_prod_next;
        end
        if (en_d) begin
            d_err_reg     <= c_err_reg;
            d_dist_reg    <= d_dist_next;
            d_reached_reg <= d_dist_next < DW'(cfg.arrive_tolerance);
        end
        if (en_e) begin
            e_sp_reg      <= SW'(cfg.linear_gain) * SW'(d_dist_reg);
            e_rp_reg      <= RW'($signed({1'b0, cfg.angular_gain})) * RW'(d_err_reg);
            e_reached_reg <= d_reached_reg;
        end
        if (en_f) begin
            f_reg <= f_next;
        end
    end

    assign out_valid = f_v_reg;
    assign out_data  = f_reg;

endmodule
